### hw/rtl/sliding_window_median_assert.svh
// Assertion macros for the sliding window median filter.
// Expects clk and rst_n in the scope of the user; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies.
package swm_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int OUT_W           = 33;
    localparam int CFG_W           = 7;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int WINDOW_SIZE_RST = 3;

    // Broadcast to every cell for one request.
    typedef struct packed {
        logic                       step;   // request accepted this cycle
        logic                       flush;  // window size written
        logic                       del;    // window full: drop the oldest sample
        logic                       clr;    // restart: empty before insert
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] oldest;
    } cell_ctrl_t;

    // Cell i to cell i+1: state after the delete phase, insert shift, delay tap.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] d_val;
        logic                       d_vld;
        logic                       g;
        logic signed [SAMPLE_W-1:0] tap;
    } cell_up_t;

    // Cell i+1 to cell i: raw sorted entry and its compare against the new sample.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic                       vld;
        logic                       gt_new;
    } cell_dn_t;

endpackage

### hw/rtl/sliding_window_median.sv
// Sliding window median: one request per cycle while no result is pending or the output side is ready.
// A request that fills or slides the window sets pend_reg, which holds until the output register is free.
// Each request goes through the sorted cell chain (drop oldest, insert new); then the
// middle cells are picked and added into the output register.
// Reset (async, active low) empties the window and sets the window size to 3;
// a window size write also empties the window.
module sliding_window_median
#(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,     // window_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] sample
    input  logic [0:0]  s_axis_tuser,    // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // [32:0] median_twice, rest zero
);

    `include "sliding_window_median_assert.svh"

    localparam int KW    = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [swm_pkg::CFG_W-1:0]              size_reg;
    logic [KW-1:0]                          k_eff;
    logic [KW-1:0]                          fill_reg;
    logic [KW-1:0]                          fill_next;
    logic                                   pend_reg;
    logic                                   out_valid_reg;
    logic signed [swm_pkg::OUT_W-1:0]       out_data_reg;
    logic                                   out_free;
    logic                                   step;
    logic                                   restart;
    logic [IDX_W-1:0]                       old_idx;
    logic [IDX_W-1:0]                       hi_idx;
    logic [IDX_W-1:0]                       lo_idx;
    logic signed [swm_pkg::SAMPLE_W-1:0]    lo_sel;
    logic signed [swm_pkg::SAMPLE_W-1:0]    hi_sel;
    logic signed [swm_pkg::OUT_W-1:0]       twice;
    logic [WINDOW_MAX-1:0]                  vld_vec;
    logic signed [swm_pkg::SAMPLE_W-1:0]    cell_val [WINDOW_MAX];
    logic signed [swm_pkg::SAMPLE_W-1:0]    cell_tap [WINDOW_MAX];
    swm_pkg::cell_ctrl_t                    ctrl;
    swm_pkg::cell_up_t                      lo_link [WINDOW_MAX+1];
    swm_pkg::cell_dn_t                      hi_link [WINDOW_MAX+1];

    // effective window size: zero reads as 1, saturates at WINDOW_MAX
    always_comb
    begin
        if (size_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(size_reg) > WINDOW_MAX)
        begin
            k_eff = KW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = KW'(size_reg);
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_free;
    assign step          = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tuser[0];

    assign old_idx = IDX_W'(k_eff - KW'(1));
    assign hi_idx  = IDX_W'(k_eff >> 1);
    assign lo_idx  = k_eff[0] ? hi_idx : (hi_idx - IDX_W'(1));

    always_comb
    begin
        if (restart)
        begin
            fill_next = KW'(1);
        end
        else if (fill_reg == k_eff)
        begin
            fill_next = k_eff;
        end
        else
        begin
            fill_next = fill_reg + KW'(1);
        end
    end

    always_comb
    begin
        ctrl.step   = step;
        ctrl.flush  = cfg_wr_en;
        ctrl.del    = !restart && (fill_reg == k_eff);
        ctrl.clr    = restart;
        ctrl.sample = s_axis_tdata;
        ctrl.oldest = cell_tap[old_idx];
    end

    // chain ends: nothing shifts in from below, an empty cell sits above the top
    // {d_val, d_vld, g, tap}
    assign lo_link[0]          = {{swm_pkg::SAMPLE_W{1'b0}}, 1'b0, 1'b0, s_axis_tdata};
    // {val, vld, gt_new}
    assign hi_link[WINDOW_MAX] = {{swm_pkg::SAMPLE_W{1'b0}}, 1'b0, 1'b1};

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .from_lo (lo_link[i]),
            .from_hi (hi_link[i+1]),
            .to_hi   (lo_link[i+1]),
            .to_lo   (hi_link[i])
        );
        assign cell_val[i] = hi_link[i].val;
        assign vld_vec[i]  = hi_link[i].vld;
        assign cell_tap[i] = lo_link[i+1].tap;
    end

    always_comb
    begin
        lo_sel = cell_val[lo_idx];
        hi_sel = cell_val[hi_idx];
        twice  = {lo_sel[swm_pkg::SAMPLE_W-1], lo_sel} + {hi_sel[swm_pkg::SAMPLE_W-1], hi_sel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= swm_pkg::CFG_W'(swm_pkg::WINDOW_SIZE_RST);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
                fill_reg <= '0;
            end
            else if (step)
            begin
                fill_reg <= fill_next;
            end
            pend_reg <= (step && (fill_next == k_eff)) || (pend_reg && !out_free);
            if (out_free)
            begin
                out_valid_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pend_reg)
        begin
            out_data_reg <= twice;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(40 - swm_pkg::OUT_W){1'b0}}, out_data_reg};

    `SWM_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= k_eff, "fill count above window size")
    `SWM_ASSERT_NOW(a_cells_match_fill, 1'b1, $countones(vld_vec) == int'(fill_reg),
        "sorted cell count differs from fill count")
    `SWM_ASSERT_NEXT(a_full_raises_pend, step && !cfg_wr_en && (fill_next == k_eff),
        pend_reg, "full window produced no pending result")
    `SWM_ASSERT_NEXT(a_pend_holds, pend_reg && !out_free, pend_reg && $stable(fill_reg),
        "pending result lost while output blocked")

endmodule

### hw/rtl/swm_cell.sv
// One cell of the sorted chain: a sorted window entry plus one delay tap.
// Depends on swm_pkg.
module swm_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  swm_pkg::cell_ctrl_t   ctrl,
    input  swm_pkg::cell_up_t     from_lo,
    input  swm_pkg::cell_dn_t     from_hi,
    output swm_pkg::cell_up_t     to_hi,
    output swm_pkg::cell_dn_t     to_lo
);

    logic signed [swm_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0] val_next;
    logic                                vld_reg;
    logic                                vld_next;
    logic signed [swm_pkg::SAMPLE_W-1:0] tap_reg;
    logic                                gt_self;
    logic                                shift;
    logic signed [swm_pkg::SAMPLE_W-1:0] d_val;
    logic                                d_vld;
    logic                                g;

    always_comb
    begin
        gt_self = val_reg > ctrl.sample;
        // first entry >= oldest is the one removed; it and all above move down
        shift   = ctrl.del && vld_reg && (val_reg >= ctrl.oldest);
        d_val   = shift ? from_hi.val : val_reg;
        d_vld   = (shift ? from_hi.vld : vld_reg) && !ctrl.clr;
        g       = !d_vld || (shift ? from_hi.gt_new : gt_self);

        if (from_lo.g)
        begin
            val_next = from_lo.d_val;
            vld_next = from_lo.d_vld;
        end
        else if (g)
        begin
            val_next = ctrl.sample;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = d_val;
            vld_next = d_vld;
        end

        to_hi.d_val  = d_val;
        to_hi.d_vld  = d_vld;
        to_hi.g      = g;
        to_hi.tap    = tap_reg;
        to_lo.val    = val_reg;
        to_lo.vld    = vld_reg;
        to_lo.gt_new = gt_self;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.flush)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            val_reg <= val_next;
            tap_reg <= from_lo.tap;
        end
    end

endmodule

### tb/tb_sliding_window_median.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_median: a scoreboard class predicts twice the window median
// for every accepted request that leaves the window full, and checks the output stream under varied stalls and sizes.
// Depends on swm_pkg and the sliding_window_median RTL only.

class median_scoreboard;
    localparam int WIN_MAX = swm_pkg::WINDOW_MAX_DEF;

    logic signed [31:0] window_vals [WIN_MAX];
    int unsigned        fill_count;
    int unsigned        next_slot;
    logic [6:0]         window_size;
    logic [32:0]        median_q [$];
    int                 failures;

    function new();
        fill_count  = 0;
        next_slot   = 0;
        window_size = 7'(swm_pkg::WINDOW_SIZE_RST);
        failures    = 0;
    endfunction

    function int unsigned span();
        if (window_size == 0)
            return 1;
        if (window_size > WIN_MAX)
            return WIN_MAX;
        return window_size;
    endfunction

    function void set_window(logic [6:0] size);
        window_size = size;
        fill_count  = 0;
        next_slot   = 0;
    endfunction

    // Accepted request: slide the window, queue a median once it is full.
    function void take_sample(logic signed [31:0] sample, logic restart);
        int unsigned k;
        int unsigned j;
        longint      sorted_vals [WIN_MAX];
        longint      v;
        longint      twice;
        k = span();
        if (restart)
        begin
            fill_count = 0;
            next_slot  = 0;
        end
        if (next_slot >= k)
            next_slot = 0;
        window_vals[next_slot] = sample;
        next_slot = (next_slot + 1 >= k) ? 0 : next_slot + 1;
        if (fill_count < k)
            fill_count++;
        if (fill_count < k)
            return;
        // insertion sort of the full window
        for (int unsigned i = 0; i < k; i++)
        begin
            v = longint'(window_vals[i]);
            j = i;
            while (j > 0 && sorted_vals[j - 1] > v)
            begin
                sorted_vals[j] = sorted_vals[j - 1];
                j--;
            end
            sorted_vals[j] = v;
        end
        if (k % 2 == 1)
            twice = 2 * sorted_vals[k / 2];
        else
            twice = sorted_vals[k / 2 - 1] + sorted_vals[k / 2];
        median_q.insert(median_q.size(), twice[32:0]);
    endfunction

    function void report(string what, logic [32:0] exp_val, logic [32:0] got_val);
        failures++;
        if (failures <= 10)
            $display("median check failed (%s): expected %0d got %0d", what,
                     $signed(exp_val), $signed(got_val));
    endfunction

    function void check_median(logic [32:0] got);
        logic [32:0] exp_val;
        if (median_q.size() == 0)
        begin
            report("unexpected result", 'x, got);
            return;
        end
        exp_val = median_q.pop_front();
        if (got !== exp_val)
            report("median_twice", exp_val, got);
    endfunction

    function int pending();
        return median_q.size();
    endfunction

    function void close_out();
        while (median_q.size() != 0)
            report("result never came", median_q.pop_front(), 'x);
    endfunction
endclass

module tb_sliding_window_median;

    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [31:0] S_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] S_MIN        = 32'h8000_0000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [6:0]  cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] sample
    logic [0:0]  s_axis_tuser  = '0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [32:0] median_twice

    median_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int unsigned hold_token     = 0;
    int unsigned hold_seen      = 0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    sliding_window_median u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sliding_window_median: mismatch");
            $finish;
        end
    end

    // Result side: check at the edge, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_median(m_axis_tdata[32:0]);
        if (hold_token != hold_seen)
        begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic push_sample(input logic [31:0] sample, input logic restart);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_sample(sample, restart);
    endtask

    // Wait for every queued median, then let the pipeline empty out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [6:0] size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_window(size);
    endtask

    function automatic logic [31:0] pick_sample();
        int unsigned mode;
        mode = $urandom_range(9);
        case (mode)
            0:       return (mode == 0 && $urandom_range(1)) ? S_MAX : S_MIN;
            1:       return $urandom_range(1) ? 32'd0 : 32'hffff_ffff;
            2, 3:    return 32'($signed($urandom_range(15)) - 8);   // dense duplicates
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(input logic [6:0] size, input int send_pct, input int stall_pct,
                             input int n_items, input bit long_hold);
        int unsigned restart_odds;
        settle();
        write_window(size);
        restart_odds   = (size >= 16 || size == 0 && 1'b0) ? 300 : 40;
        send_idle_pct  = send_pct;
        sink_stall_pct <= stall_pct;
        if (long_hold)
            hold_token <= hold_token + 1;
        for (int i = 0; i < n_items; i++)
            push_sample(pick_sample(), $urandom_range(restart_odds - 1) == 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size of 3: extremes, restart mid-stream, extreme outputs both ways.
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'hffff_ffff, 1'b0);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MAX, 1'b0);
        // Even window: half units show up.
        settle();
        write_window(7'd2);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MAX, 1'b0);
        push_sample(32'd1, 1'b1);
        push_sample(32'hffff_ffff, 1'b0);
        // Size zero behaves as one.
        settle();
        write_window(7'd0);
        push_sample(32'd7, 1'b0);
        push_sample(32'hffff_fff9, 1'b0);
        // Oversize saturates at the maximum; these only fill.
        settle();
        write_window(7'd65);
        push_sample(32'd3, 1'b0);
        push_sample(S_MIN, 1'b0);

        run_phase(7'd5,   0,  0,  180, 1'b1);
        run_phase(7'd4,   85, 0,  180, 1'b0);
        run_phase(7'd1,   0,  85, 180, 1'b0);
        run_phase(7'd64,  24, 24, 180, 1'b0);
        run_phase(7'd127, 0,  0,  180, 1'b0);
        run_phase(7'd2,   24, 24, 180, 1'b0);
        run_phase(7'd0,   85, 0,  180, 1'b0);
        run_phase(7'd63,  0,  85, 180, 1'b0);
        run_phase(7'($urandom_range(1, 64)), 24, 24, 180, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("sliding_window_median: match");
        else
            $display("sliding_window_median: mismatch");
        $finish;
    end
endmodule
